// File: design/tbba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbba_pkg;

    // Default sizes
    localparam int MAX_BLOCKS_DEF   = 4096;
    localparam int BITMAP_WORDS_DEF = 64;

    // Bitmap word geometry
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int IDX_W  = 12;
    localparam int CFG_W  = 13;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    // Request codes
    localparam logic [FUNC_W-1:0] FN_ALLOC_LO = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC_HI = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PROBE_LO = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PROBE_HI = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FREE     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SET      = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  block_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] block_number;
        logic             found;
    } rsp_t;

    // Result of a free-bit search within one word
    typedef struct packed {
        logic             any;
        logic [BIT_W-1:0] pos;
    } find_t;

endpackage

`default_nettype wire

// File: design/tbba_word_find.sv
`timescale 1ns / 1ps
`default_nettype none

module tbba_word_find (
    input  wire logic [tbba_pkg::WORD_BITS-1:0] word,
    input  wire logic [tbba_pkg::WORD_BITS-1:0] mask,
    input  wire logic                           from_top,
    output tbba_pkg::find_t                     hit
);
    import tbba_pkg::*;

    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] scan_vec;
    logic [BIT_W-1:0]     low_pos;

    // Free bits inside the valid range; reversed for a top-down search
    always_comb
    begin
        free_vec = ~word & mask;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            scan_vec[i] = from_top ? free_vec[WORD_BITS-1-i] : free_vec[i];
        end
    end

    // Lowest set bit of the scan vector
    always_comb
    begin
        low_pos = '0;
        for (int i = WORD_BITS-1; i >= 0; i--)
        begin
            if (scan_vec[i])
            begin
                low_pos = BIT_W'(i);
            end
        end
    end

    assign hit.any = |scan_vec;
    assign hit.pos = from_top ? (BIT_W'(WORD_BITS-1) - low_pos) : low_pos;

endmodule

`default_nettype wire

// File: design/two_ended_block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// A search issues one word read per cycle into the registered RAM read port, checks
// each returned word and registers done on a hit or after the last word; free/set
// reads, modifies and writes back the indexed word, then strobes; an empty partition,
// bad index or unused code strobes straight from idle. A new beat is taken in the
// cycle its predecessor strobes. Reset: asynchronous, clears control, sets the size to
// 4096; a clearing pass zeroes the bitmap while busy is high. Results cannot stall.
module two_ended_block_bitmap_allocator #(
    parameter int MAX_BLOCKS   = tbba_pkg::MAX_BLOCKS_DEF,
    parameter int BITMAP_WORDS = tbba_pkg::BITMAP_WORDS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  tbba_pkg::req_t                   req,
    output logic                             busy,
    output logic                             done,
    output tbba_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_we,
    input  wire logic [tbba_pkg::CFG_W-1:0]  cfg_wdata
);
    import tbba_pkg::*;

    localparam int WA_W    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WC_W    = $clog2(BITMAP_WORDS + 1);
    localparam int CAP     = (MAX_BLOCKS < BITMAP_WORDS * WORD_BITS) ?
                             MAX_BLOCKS : BITMAP_WORDS * WORD_BITS;
    localparam int CAP_SAT = (CAP > 8191) ? 8191 : CAP;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN} state_t;

    // Control state
    state_t              state_reg,     state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [FUNC_W-1:0]   func_reg,      func_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic [WA_W-1:0]     last_word_reg, last_word_next;
    logic [BIT_W-1:0]    top_bit_reg,   top_bit_next;
    logic [WA_W-1:0]     iss_word_reg,  iss_word_next;
    logic [WC_W-1:0]     iss_cnt_reg,   iss_cnt_next;
    logic                dat_vld_reg,   dat_vld_next;
    logic                dat_last_reg,  dat_last_next;
    logic [WA_W-1:0]     dat_word_reg,  dat_word_next;
    logic [WA_W-1:0]     clr_addr_reg,  clr_addr_next;
    logic                done_reg,      done_next;
    rsp_t                rsp_reg,       rsp_next;

    // Bitmap RAM
    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [WA_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Decode helpers
    logic [CFG_W-1:0]     lim;
    logic [CFG_W-1:0]     lim_m1;
    logic [WA_W-1:0]      last_word_in;
    logic [WA_W-1:0]      idx_word_in;
    logic                 req_top;
    logic                 cur_top;
    logic                 cur_alloc;
    logic [WORD_BITS-1:0] dat_mask;
    logic [WORD_BITS-1:0] idx_bit;
    find_t                hit;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Effective size and the word holding the top valid block
    always_comb
    begin
        lim          = (cfg_reg > CFG_W'(CAP_SAT)) ? CFG_W'(CAP_SAT) : cfg_reg;
        lim_m1       = lim - CFG_W'(1);
        last_word_in = WA_W'({{WA_W{1'b0}}, lim_m1[CFG_W-1:BIT_W]});
        idx_word_in  = WA_W'({{WA_W{1'b0}}, req.block_index[IDX_W-1:BIT_W]});
        req_top      = (req.func == FN_ALLOC_HI) || (req.func == FN_PROBE_HI);
        cur_top      = (func_reg == FN_ALLOC_HI) || (func_reg == FN_PROBE_HI);
        cur_alloc    = (func_reg == FN_ALLOC_LO) || (func_reg == FN_ALLOC_HI);
        idx_bit      = WORD_BITS'(1) << idx_reg[BIT_W-1:0];
    end

    // Blocks beyond the limit count as used in the top word
    assign dat_mask = (dat_word_reg == last_word_reg) ?
                      ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS-1) - top_bit_reg)) :
                      {WORD_BITS{1'b1}};

    tbba_word_find u_find (
        .word     (rd_data_reg),
        .mask     (dat_mask),
        .from_top (cur_top),
        .hit      (hit)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        last_word_next = last_word_reg;
        top_bit_next   = top_bit_reg;
        iss_word_next  = iss_word_reg;
        iss_cnt_next   = iss_cnt_reg;
        dat_vld_next   = 1'b0;
        dat_last_next  = dat_last_reg;
        dat_word_next  = dat_word_reg;
        clr_addr_next  = clr_addr_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = dat_word_reg;
        wr_data        = rd_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
                if (clr_addr_reg == WA_W'(BITMAP_WORDS-1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + WA_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    func_next      = req.func;
                    idx_next       = req.block_index;
                    last_word_next = last_word_in;
                    top_bit_next   = lim_m1[BIT_W-1:0];
                    case (req.func)
                        FN_ALLOC_LO, FN_ALLOC_HI, FN_PROBE_LO, FN_PROBE_HI:
                        begin
                            if (lim == '0)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '0;
                            end
                            else
                            begin
                                state_next    = ST_SCAN;
                                iss_word_next = req_top ? last_word_in : '0;
                                iss_cnt_next  = WC_W'(last_word_in) + WC_W'(1);
                            end
                        end
                        FN_FREE, FN_SET:
                        begin
                            if ({1'b0, req.block_index} < lim)
                            begin
                                state_next    = ST_SCAN;
                                iss_word_next = idx_word_in;
                                iss_cnt_next  = WC_W'(1);
                            end
                            else
                            begin
                                done_next             = 1'b1;
                                rsp_next.block_number = req.block_index;
                                rsp_next.found        = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one word read per cycle
                if (iss_cnt_reg != '0)
                begin
                    rd_en         = 1'b1;
                    dat_vld_next  = 1'b1;
                    dat_word_next = iss_word_reg;
                    dat_last_next = (iss_cnt_reg == WC_W'(1));
                    iss_cnt_next  = iss_cnt_reg - WC_W'(1);
                    iss_word_next = cur_top ? (iss_word_reg - WA_W'(1)) :
                                              (iss_word_reg + WA_W'(1));
                end

                // Evaluate the word returned by the RAM
                if (dat_vld_reg)
                begin
                    case (func_reg)
                        FN_FREE, FN_SET:
                        begin
                            wr_en   = 1'b1;
                            wr_data = (func_reg == FN_SET) ? (rd_data_reg | idx_bit) :
                                                             (rd_data_reg & ~idx_bit);
                            done_next             = 1'b1;
                            rsp_next.block_number = idx_reg;
                            rsp_next.found        = 1'b1;
                            state_next            = ST_IDLE;
                            iss_cnt_next          = '0;
                            dat_vld_next          = 1'b0;
                        end
                        default:
                        begin
                            if (hit.any)
                            begin
                                wr_en     = cur_alloc;
                                wr_data   = rd_data_reg | (WORD_BITS'(1) << hit.pos);
                                done_next = 1'b1;
                                rsp_next.block_number =
                                    IDX_W'({{IDX_W{1'b0}}, dat_word_reg, hit.pos});
                                rsp_next.found = 1'b1;
                                state_next     = ST_IDLE;
                                iss_cnt_next   = '0;
                                dat_vld_next   = 1'b0;
                            end
                            else if (dat_last_reg)
                            begin
                                done_next    = 1'b1;
                                rsp_next     = '0;
                                state_next   = ST_IDLE;
                                iss_cnt_next = '0;
                                dat_vld_next = 1'b0;
                            end
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cfg_reg       <= CFG_RESET;
            iss_cnt_reg   <= '0;
            dat_vld_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_cnt_reg   <= iss_cnt_next;
            dat_vld_reg   <= dat_vld_next;
            clr_addr_reg  <= clr_addr_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        idx_reg       <= idx_next;
        last_word_reg <= last_word_next;
        top_bit_reg   <= top_bit_next;
        iss_word_reg  <= iss_word_next;
        dat_last_reg  <= dat_last_next;
        dat_word_reg  <= dat_word_next;
    end

    // Bitmap RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[iss_word_reg];
        end
    end

    // A strobe follows either an accepted beat or the end of a scan
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN || (start && !busy)))
        else $error("done without a request or scan");

    // Results never overlap the busy window
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // No bitmap write while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("bitmap write while idle");

    // Returned word data only while scanning
    a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dat_vld_reg |-> (state_reg == ST_SCAN) && $past(rd_en))
        else $error("word data without a read");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tbba_pkg::*;

    localparam int TB_MAX_BLOCKS = MAX_BLOCKS_DEF;
    localparam int TB_WORDS      = BITMAP_WORDS_DEF;
    localparam int FULL_SCAN     = BITMAP_WORDS_DEF + 8;
    localparam int PHASE_ITEMS   = 125;

    // codes outside the defined request set
    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    // Shadow copy of the bitmap and the size register; predicts each response
    class block_map_tracker;
        bit [WORD_BITS-1:0] used_words [TB_WORDS];
        int unsigned        part_size;
        rsp_t               expected_rsp [$];
        int                 errors;

        function new();
            foreach (used_words[w]) used_words[w] = '0;
            part_size = 32'(CFG_RESET);
            errors    = 0;
        endfunction

        function void write_size(logic [CFG_W-1:0] v);
            part_size = 32'(v);
        endfunction

        function int unsigned eff_size();
            if (part_size > TB_MAX_BLOCKS) return TB_MAX_BLOCKS;
            return part_size;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Accepted request beat: update the shadow map and queue the response
        function void note_request(req_t r);
            int unsigned lim;
            int unsigned b;
            int unsigned i;
            int unsigned idx;
            bit          hit;
            bit          from_top;
            rsp_t        e;
            lim = eff_size();
            e   = '0;
            b   = 0;
            idx = 32'(r.block_index);
            case (r.func)
                FN_ALLOC_LO, FN_ALLOC_HI, FN_PROBE_LO, FN_PROBE_HI:
                begin
                    hit      = 1'b0;
                    from_top = (r.func == FN_ALLOC_HI) || (r.func == FN_PROBE_HI);
                    for (i = 0; i < lim && !hit; i++)
                    begin
                        b = from_top ? (lim - 1 - i) : i;
                        if (!used_words[b / WORD_BITS][b % WORD_BITS]) hit = 1'b1;
                    end
                    if (hit)
                    begin
                        if (r.func == FN_ALLOC_LO || r.func == FN_ALLOC_HI)
                            used_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
                        e.block_number = b[IDX_W-1:0];
                        e.found        = 1'b1;
                    end
                end
                FN_FREE, FN_SET:
                begin
                    e.block_number = r.block_index;
                    if (idx < lim)
                    begin
                        used_words[idx / WORD_BITS][idx % WORD_BITS] = (r.func == FN_SET);
                        e.found = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_rsp.push_back(e);
        endfunction

        // Response beat: compare against the oldest queued prediction
        function void check_response(rsp_t r);
            rsp_t e;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected response: block_number %0d found %0b",
                       r.block_number, r.found);
                errors++;
                return;
            end
            e = expected_rsp.pop_front();
            if (r.block_number !== e.block_number)
            begin
                $error("block_number: expected %0d, actual %0d", e.block_number,
                       r.block_number);
                errors++;
            end
            if (r.found !== e.found)
            begin
                $error("found: expected %0b, actual %0b", e.found, r.found);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    req_t             req;
    logic             busy;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    block_map_tracker tracker;

    two_ended_block_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // monitor: config writes, accepted request beats, response beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we) tracker.write_size(cfg_wdata);
            if (done) tracker.check_response(rsp);
            if (start && !busy) tracker.note_request(req);
        end
    end

    function automatic req_t make_req(logic [FUNC_W-1:0] f, int unsigned idx);
        req_t r;
        r.func        = f;
        r.block_index = idx[IDX_W-1:0];
        return r;
    endfunction

    // random request shaped for the current size; indices mostly near the valid range
    function automatic req_t random_req(int unsigned lim);
        int unsigned p;
        int unsigned span;
        req_t        r;
        p    = $urandom_range(0, 99);
        span = (lim + 8 > TB_MAX_BLOCKS - 1) ? TB_MAX_BLOCKS - 1 : lim + 8;
        if (p < 30)      r.func = FN_ALLOC_LO;
        else if (p < 50) r.func = FN_ALLOC_HI;
        else if (p < 58) r.func = FN_PROBE_LO;
        else if (p < 66) r.func = FN_PROBE_HI;
        else if (p < 83) r.func = FN_FREE;
        else if (p < 95) r.func = FN_SET;
        else             r.func = ($urandom_range(0, 1) != 0) ? FN_UNUSED_7 : FN_UNUSED_6;
        if ($urandom_range(0, 99) < 70)
            r.block_index = IDX_W'($urandom_range(0, span));
        else
            r.block_index = IDX_W'($urandom_range(0, TB_MAX_BLOCKS - 1));
        return r;
    endfunction

    // one request beat; optional random idle cycles before it
    task automatic send_req(req_t r, bit allow_idle);
        int unsigned gap;
        if (allow_idle && $urandom_range(0, 99) < 26)
        begin
            gap   = $urandom_range(1, 6);
            start <= 1'b0;
            req   <= req_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        // accepted at the edge where busy was low
        do @(posedge clk); while (busy);
    endtask

    // stop sending and wait until every response is in
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_partition(int unsigned v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    int unsigned phase_sizes [10] = '{130, 1, 8191, 64, 65, 0, 4096, 200, 4095, 127};

    initial
    begin
        tracker   = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // let the clearing pass finish
        repeat (2) @(posedge clk);
        while (busy) @(posedge clk);

        // directed: full partition, both ends, repeat free/set
        send_req(make_req(FN_ALLOC_LO, 0), 1'b1);
        send_req(make_req(FN_ALLOC_HI, 4095), 1'b1);
        send_req(make_req(FN_PROBE_LO, 4095), 1'b1);
        send_req(make_req(FN_PROBE_HI, 0), 1'b1);
        send_req(make_req(FN_FREE, 0), 1'b1);
        send_req(make_req(FN_FREE, 0), 1'b1);
        send_req(make_req(FN_SET, 4095), 1'b1);
        send_req(make_req(FN_SET, 4094), 1'b1);
        send_req(make_req(FN_PROBE_HI, 4095), 1'b1);
        send_req(make_req(FN_ALLOC_LO, 0), 1'b1);
        send_req(make_req(FN_FREE, 4095), 1'b1);
        send_req(make_req(FN_ALLOC_HI, 0), 1'b1);
        send_req(make_req(FN_UNUSED_6, 4095), 1'b1);
        send_req(make_req(FN_UNUSED_7, 0), 1'b1);
        drain();

        // one-block partition: nothing free, index out of range
        write_partition(1);
        send_req(make_req(FN_ALLOC_LO, 0), 1'b1);
        send_req(make_req(FN_ALLOC_HI, 0), 1'b1);
        send_req(make_req(FN_PROBE_LO, 0), 1'b1);
        send_req(make_req(FN_FREE, 1), 1'b1);
        send_req(make_req(FN_SET, 4095), 1'b1);
        send_req(make_req(FN_FREE, 0), 1'b1);
        send_req(make_req(FN_PROBE_HI, 0), 1'b1);
        send_req(make_req(FN_SET, 0), 1'b1);
        drain();

        // empty partition
        write_partition(0);
        send_req(make_req(FN_ALLOC_LO, 0), 1'b1);
        send_req(make_req(FN_FREE, 0), 1'b1);
        send_req(make_req(FN_SET, 0), 1'b1);
        send_req(make_req(FN_PROBE_HI, 0), 1'b1);
        drain();

        // random phases over several sizes; two phases with no idling
        foreach (phase_sizes[ph])
        begin
            write_partition(phase_sizes[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_req(random_req(tracker.eff_size()), !(ph == 3 || ph == 4));
            drain();
        end

        // tail: let any stray response show up
        repeat (FULL_SCAN) @(posedge clk);
        if (tracker.pending() != 0)
        begin
            $error("%0d responses never arrived", tracker.pending());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
